// ===== rtl/core/kmcd_pkg.sv =====
// shared constants and types for the key matrix change detector
package kmcd_pkg;

    localparam int MAX_ROWS     = 8;
    localparam int MAX_KEYS     = 64;
    localparam int COL_W        = 3;
    localparam int ROW_W        = 3;
    localparam int KEY_W        = 6;
    localparam int LEVELS_W     = 8;
    localparam int DEF_KEYS     = 64;
    localparam int DEF_ROWS     = 8;
    localparam int COLS_DIRECT  = 6;
    localparam int COL_MIRROR   = 13;

    // what the row lanes found for one column sample
    typedef struct packed {
        logic [MAX_ROWS-1:0] change;
        logic [MAX_ROWS-1:0] pressed;
        logic [COL_W-1:0]    offset;
    } lane_res_t;

    // columns 6 and 7 are wired in swapped order
    function automatic logic [COL_W-1:0] map_column(input logic [COL_W-1:0] col);
        logic [COL_W-1:0] res;
        if (col < COL_W'(COLS_DIRECT)) begin
            res = col;
        end
        else begin
            res = COL_W'(COL_MIRROR) - col;
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/key_matrix_change_detector.sv =====
// top level of the key matrix change detector
// Takes one column sample per input transfer (column number and the
// active-low row levels) and compares it with the stored key map. One
// output transfer follows for each key whose level changed, in ascending
// row order, carrying the key index, the new level and a last flag on the
// final event of the sample. A sample with no change gives no output.
// Each row is a lane of its own holding the levels of that row's keys,
// so all rows are compared in the cycle the sample is accepted; a merging
// stage then hands the changes out one per cycle while out_ready is high.
// The first event passes through the event queue and then the output
// register. A sample gives at most ROWS events, and the next sample is
// accepted in the cycle the last event of the current one moves to the
// output register.
// Reset clears the key map to all released and drops all queued events.
// While the receiver stalls, the output register holds its event and the
// input is refused as long as any event of the current sample is queued.
module key_matrix_change_detector #(
    parameter int KEYS = kmcd_pkg::DEF_KEYS,
    parameter int ROWS = kmcd_pkg::DEF_ROWS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [kmcd_pkg::COL_W-1:0]      column,
    input  logic [kmcd_pkg::LEVELS_W-1:0]   row_levels,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [kmcd_pkg::KEY_W-1:0]      key_index,
    output logic                            pressed,
    output logic                            last
);

    kmcd_pkg::lane_res_t        lanes;
    logic                       accept;
    logic [kmcd_pkg::COL_W-1:0] offset;

    assign offset       = kmcd_pkg::map_column(column);
    assign lanes.offset = offset;

    generate
        for (genvar r = 0; r < kmcd_pkg::MAX_ROWS; r++) begin : g_row
            if (r < ROWS) begin : g_lane
                kmcd_lane #(
                    .ROW  (r),
                    .KEYS (KEYS)
                ) u_lane (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .accept  (accept),
                    .offset  (offset),
                    .level   (row_levels[r]),
                    .change  (lanes.change[r]),
                    .pressed (lanes.pressed[r])
                );
            end
            else begin : g_none
                // rows beyond the row count are not scanned
                assign lanes.change[r]  = 1'b0;
                assign lanes.pressed[r] = 1'b0;
            end
        end
    endgenerate

    kmcd_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .accept    (accept),
        .lanes     (lanes),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_index (key_index),
        .pressed   (pressed),
        .last      (last)
    );

`ifndef SYNTHESIS
    // no event for a key that does not exist
    a_key_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, key_index} < (kmcd_pkg::KEY_W + 1)'(KEYS)))
        else $error("event for a key beyond the key count");
`endif

endmodule

// ===== rtl/core/kmcd_lane.sv =====
// one row lane: stored levels of the row's keys and change detection
module kmcd_lane #(
    parameter int ROW  = 0,
    parameter int KEYS = kmcd_pkg::DEF_KEYS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [kmcd_pkg::COL_W-1:0]  offset,
    input  logic                        level,
    output logic                        change,
    output logic                        pressed
);

    localparam int BASE = ROW * 8;
    localparam int CMP_W = kmcd_pkg::KEY_W + 1;

    logic [7:0] levels_reg;
    logic [7:0] levels_next;
    logic       enable;
    logic       now;

    // keys at or above the key count do not exist
    assign enable  = (CMP_W'(BASE) + CMP_W'(offset)) < CMP_W'(KEYS);
    assign now     = ~level;
    assign change  = enable && (now != levels_reg[offset]);
    assign pressed = now;

    always_comb
    begin
        levels_next = levels_reg;
        if (accept && enable) begin
            levels_next[offset] = now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            levels_reg <= '0;
        end
        else begin
            levels_reg <= levels_next;
        end
    end

endmodule

// ===== rtl/core/kmcd_merge.sv =====
// merging stage: queues the lane results and serialises change events
module kmcd_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        accept,
    input  kmcd_pkg::lane_res_t         lanes,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [kmcd_pkg::KEY_W-1:0]  key_index,
    output logic                        pressed,
    output logic                        last
);

    localparam int R = kmcd_pkg::MAX_ROWS;

    logic [R-1:0]                   mask_reg, mask_next;
    logic [R-1:0]                   prs_reg, prs_next;
    logic [kmcd_pkg::COL_W-1:0]     off_reg, off_next;
    logic                           valid_reg, valid_next;
    logic [kmcd_pkg::KEY_W-1:0]     key_reg, key_next;
    logic                           pressed_reg, pressed_next;
    logic                           last_reg, last_next;
    logic [kmcd_pkg::ROW_W-1:0]     sel;
    logic                           found;
    logic                           advance;
    logic                           pop;
    logic [R-1:0]                   mask_after;

    // lowest pending row goes out first
    always_comb
    begin
        sel   = '0;
        found = 1'b0;
        for (int i = 0; i < R; i++) begin
            if (!found && mask_reg[i]) begin
                sel   = kmcd_pkg::ROW_W'(i);
                found = 1'b1;
            end
        end
    end

    assign advance    = !valid_reg || out_ready;
    assign pop        = advance && (mask_reg != '0);
    assign mask_after = pop ? (mask_reg & ~(R'(1) << sel)) : mask_reg;
    assign in_ready   = (mask_after == '0);
    assign accept     = in_valid && in_ready;

    always_comb
    begin
        mask_next    = mask_after;
        prs_next     = prs_reg;
        off_next     = off_reg;
        valid_next   = valid_reg;
        key_next     = key_reg;
        pressed_next = pressed_reg;
        last_next    = last_reg;
        if (accept) begin
            mask_next = lanes.change;
            prs_next  = lanes.pressed;
            off_next  = lanes.offset;
        end
        if (advance) begin
            valid_next   = (mask_reg != '0);
            key_next     = {sel, off_reg};
            pressed_next = prs_reg[sel];
            last_next    = (mask_after == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prs_reg     <= prs_next;
        off_reg     <= off_next;
        key_reg     <= key_next;
        pressed_reg <= pressed_next;
        last_reg    <= last_next;
    end

    assign out_valid = valid_reg;
    assign key_index = key_reg;
    assign pressed   = pressed_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    // a new sample is only taken once at most one event is left to go
    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> ($countones(mask_reg) <= 1))
        else $error("input ready with several events still queued");

    // an event that is not the last leaves more events queued
    a_not_last_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !last_reg) |-> (mask_reg != '0))
        else $error("non-final event with nothing queued behind it");
`endif

endmodule
